/* sv/quintic_trajectory_evaluator_top_macros.svh */
// Assertion macros for the quintic trajectory evaluator.
`ifndef QUINTIC_TRAJECTORY_EVALUATOR_TOP_MACROS_SVH
`define QUINTIC_TRAJECTORY_EVALUATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define QTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define QTE_ASSERT_NOW(lbl, ante, cons, msg)
`define QTE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/qte_pkg.sv */
// Shared types, codes and arithmetic helpers of the quintic trajectory evaluator.
`timescale 1ns / 1ps
package qte_pkg;

  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_GOAL = 2'd1;
  localparam logic [1:0] OP_EVAL      = 2'd2;

  localparam logic [1:0] REG_START = 2'd0;
  localparam logic [1:0] REG_END   = 2'd1;
  localparam logic [1:0] REG_DOFS  = 2'd2;

  localparam int NUM_COEF = 6;
  localparam int NUM_STEP = 15;
  localparam int ACC_W    = 122;
  localparam int PROD_W   = 118;

  localparam logic [63:0] PW_ONE = 64'h0000_0000_0100_0000;
  localparam logic [95:0] HALF96 = 96'h80_0000;
  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(24'h80_0000);
  localparam logic signed [ACC_W-25:0] V_MAX = (ACC_W-24)'(48'sh7FFF_FFFF_FFFF);
  localparam logic signed [ACC_W-25:0] V_MIN = (ACC_W-24)'(48'sh8000_0000_0000);

  typedef enum logic [1:0] {
    KIND_COEF,
    KIND_GOAL,
    KIND_EVAL
  } qte_kind_t;

  typedef enum logic [1:0] {
    SEL_POS,
    SEL_VEL,
    SEL_ACC
  } qte_sel_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POW,
    BK_MAC,
    BK_EMIT,
    BK_GREAD,
    BK_GEMIT
  } qte_state_t;

  typedef struct packed {
    qte_kind_t   kind;
    logic [2:0]  dof;
    logic [2:0]  ci;
    logic [47:0] value;
    logic [31:0] stime;
    logic        past;
    logic        early;
    logic [3:0]  count;
  } qte_cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic [1:0] cnt;
  } qte_q_status_t;

  typedef struct packed {
    logic [2:0] k;
    logic [2:0] j;
    qte_sel_t   sel;
    logic [4:0] w;
  } qte_step_t;

  // One product of the multiply-accumulate sequence: coefficient k, power j,
  // target sum and derivative weight.
  function automatic qte_step_t qte_step(input logic [3:0] s);
    qte_step_t r;
    unique case (s)
      4'd0:    r = '{k: 3'd0, j: 3'd0, sel: SEL_POS, w: 5'd1};
      4'd1:    r = '{k: 3'd1, j: 3'd1, sel: SEL_POS, w: 5'd1};
      4'd2:    r = '{k: 3'd2, j: 3'd2, sel: SEL_POS, w: 5'd1};
      4'd3:    r = '{k: 3'd3, j: 3'd3, sel: SEL_POS, w: 5'd1};
      4'd4:    r = '{k: 3'd4, j: 3'd4, sel: SEL_POS, w: 5'd1};
      4'd5:    r = '{k: 3'd5, j: 3'd5, sel: SEL_POS, w: 5'd1};
      4'd6:    r = '{k: 3'd1, j: 3'd0, sel: SEL_VEL, w: 5'd1};
      4'd7:    r = '{k: 3'd2, j: 3'd1, sel: SEL_VEL, w: 5'd2};
      4'd8:    r = '{k: 3'd3, j: 3'd2, sel: SEL_VEL, w: 5'd3};
      4'd9:    r = '{k: 3'd4, j: 3'd3, sel: SEL_VEL, w: 5'd4};
      4'd10:   r = '{k: 3'd5, j: 3'd4, sel: SEL_VEL, w: 5'd5};
      4'd11:   r = '{k: 3'd2, j: 3'd0, sel: SEL_ACC, w: 5'd2};
      4'd12:   r = '{k: 3'd3, j: 3'd1, sel: SEL_ACC, w: 5'd6};
      4'd13:   r = '{k: 3'd4, j: 3'd2, sel: SEL_ACC, w: 5'd12};
      4'd14:   r = '{k: 3'd5, j: 3'd3, sel: SEL_ACC, w: 5'd20};
      default: r = '{k: 3'd0, j: 3'd0, sel: SEL_POS, w: 5'd0};
    endcase
    return r;
  endfunction

  // Round half up from Q.48 to Q.24, then clamp to the signed 48-bit range.
  function automatic logic [47:0] qte_round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0]  r;
    logic signed [ACC_W-25:0] v;
    logic [47:0]              res;
    r = a + ACC_HALF;
    v = r[ACC_W-1:24];
    if (v > V_MAX) begin
      res = V_MAX[47:0];
    end else if (v < V_MIN) begin
      res = V_MIN[47:0];
    end else begin
      res = v[47:0];
    end
    return res;
  endfunction

endpackage

/* sv/qte_front.sv */
// Front end: decode input items, drop ignored ones, tag evaluate items.
`timescale 1ns / 1ps
module qte_front #(
  parameter int NUM_DOF = 8
) (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic [2:0]            dof_index,
  input  logic [2:0]            coef_index,
  input  logic [47:0]           load_value,
  input  logic [31:0]           sample_time,
  input  logic [31:0]           start_time,
  input  logic [31:0]           end_time,
  input  logic [3:0]            dof_count,
  input  qte_pkg::qte_q_status_t q_stat,
  output logic                  push,
  output qte_pkg::qte_cmd_t     push_cmd
);
  import qte_pkg::*;

  localparam int DOF_USE = (NUM_DOF < 8) ? NUM_DOF : 8;

  logic       keep;
  logic       dof_ok;
  logic [3:0] cnt;

  assign in_ready = !q_stat.full;
  assign dof_ok   = (32'(dof_index) < NUM_DOF);

  always_comb begin
    unique case (opcode)
      OP_LOAD_COEF: keep = dof_ok && (32'(coef_index) < NUM_COEF);
      OP_LOAD_GOAL: keep = dof_ok;
      OP_EVAL:      keep = 1'b1;
      default:      keep = 1'b0;
    endcase
  end

  // Clamp the per-item joint count to one..DOF_USE.
  always_comb begin
    cnt = (dof_count == 4'd0) ? 4'd1 : dof_count;
    if (32'(cnt) > DOF_USE) begin
      cnt = 4'(DOF_USE);
    end
  end

  always_comb begin
    unique case (opcode)
      OP_LOAD_COEF: push_cmd.kind = KIND_COEF;
      OP_LOAD_GOAL: push_cmd.kind = KIND_GOAL;
      default:      push_cmd.kind = KIND_EVAL;
    endcase
    push_cmd.dof    = dof_index;
    push_cmd.ci     = coef_index;
    push_cmd.value  = load_value;
    push_cmd.stime  = sample_time;
    push_cmd.past   = (sample_time > end_time);
    push_cmd.early  = (sample_time < start_time);
    push_cmd.count  = cnt;
  end

  assign push = in_valid && in_ready && keep;

endmodule

/* sv/qte_queue.sv */
// Two-entry command queue between front end and back end.
`timescale 1ns / 1ps
module qte_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  qte_pkg::qte_cmd_t      push_cmd,
  input  logic                   pop,
  output qte_pkg::qte_cmd_t      head,
  output qte_pkg::qte_q_status_t stat
);
  import qte_pkg::*;

  qte_cmd_t   ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;

  assign head       = ent_r[rd_ptr_r];
  assign stat.cnt   = cnt_r;
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

/* sv/qte_back.sv */
// Back end: coefficient and goal stores, power unit, multiply-accumulate and result register.
`timescale 1ns / 1ps
module qte_back #(
  parameter int NUM_DOF = 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  qte_pkg::qte_cmd_t      head,
  input  qte_pkg::qte_q_status_t q_stat,
  output logic                   pop,
  output logic                   emit,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             dof_out,
  output logic [47:0]            position,
  output logic [47:0]            velocity,
  output logic [47:0]            acceleration,
  output logic                   before_start,
  output logic                   is_last
);
  import qte_pkg::*;

  localparam int DOF_USE = (NUM_DOF < 8) ? NUM_DOF : 8;
  localparam int DW      = (DOF_USE > 1) ? $clog2(DOF_USE) : 1;
  localparam int GDEPTH  = 1 << DW;
  localparam int CDEPTH  = GDEPTH * 8;

  qte_state_t st_r, st_nxt;
  qte_cmd_t   cmd_r;
  qte_step_t  step_cur;
  qte_step_t  tag1_r, tag2_r, tag3_r, tag4_r;

  logic [47:0] coef_mem [CDEPTH];
  logic [47:0] goal_mem [GDEPTH];
  logic [47:0] coef_q_r;
  logic [47:0] goal_q_r;

  logic [63:0] pw_r [NUM_COEF];
  logic [63:0] pw_last_r;
  logic [63:0] pp_lo_r, pp_hi_r;
  logic [95:0] pw_sum;
  logic [63:0] pw_sel;

  logic signed [53:0]       cw_r;
  logic [63:0]              ll_r, lh_r;
  logic [54:0]              hl_r, hh_r;
  logic [PROD_W-1:0]        prod_r;
  logic signed [ACC_W-1:0]  acc_pos_r, acc_vel_r, acc_acc_r;
  logic signed [ACC_W-1:0]  prod_ext;

  logic [2:0] d_r;
  logic [2:0] k_r;
  logic       ph_r;
  logic [4:0] s_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       out_valid_r;

  logic out_free, last, coef_rd, goal_rd, emit_acc, emit_goal;
  logic coef_wr, goal_wr, load_eval, mac_enter;

  assign step_cur = qte_step(s_r[3:0]);
  assign out_free = !out_valid_r || out_ready;
  assign last     = ((4'(d_r) + 4'd1) == cmd_r.count);
  assign pw_sum   = {32'b0, pp_lo_r} + {pp_hi_r, 32'b0} + HALF96;
  assign pw_sel   = pw_r[tag2_r.j];
  assign prod_ext = ACC_W'($signed(prod_r));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!q_stat.empty && head.kind == KIND_EVAL) begin
          st_nxt = head.past ? BK_GREAD : BK_POW;
        end
      end
      BK_POW: begin
        if (ph_r && k_r == 3'd5) begin
          st_nxt = BK_MAC;
        end
      end
      BK_MAC: begin
        if (s_r == 5'd19) begin
          st_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          st_nxt = last ? BK_IDLE : BK_MAC;
        end
      end
      BK_GREAD: st_nxt = BK_GEMIT;
      BK_GEMIT: begin
        if (out_free) begin
          st_nxt = last ? BK_IDLE : BK_GREAD;
        end
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  // Control strobes.
  always_comb begin
    pop       = (st_r == BK_IDLE) && !q_stat.empty;
    coef_wr   = pop && (head.kind == KIND_COEF);
    goal_wr   = pop && (head.kind == KIND_GOAL);
    load_eval = pop && (head.kind == KIND_EVAL);
    coef_rd   = (st_r == BK_MAC) && (s_r < 5'(NUM_STEP));
    goal_rd   = (st_r == BK_GREAD);
    emit_acc  = (st_r == BK_EMIT) && out_free;
    emit_goal = (st_r == BK_GEMIT) && out_free;
    mac_enter = (st_nxt == BK_MAC) && (st_r != BK_MAC);
    emit      = emit_acc || emit_goal;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= BK_IDLE;
      d_r         <= 3'd0;
      k_r         <= 3'd1;
      ph_r        <= 1'b0;
      s_r         <= 5'd0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      v1_r <= coef_rd;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      if (load_eval) begin
        d_r  <= 3'd0;
        k_r  <= 3'd1;
        ph_r <= 1'b0;
      end else if (st_r == BK_POW) begin
        ph_r <= ~ph_r;
        if (ph_r) begin
          k_r <= k_r + 3'd1;
        end
      end
      if (mac_enter) begin
        s_r <= 5'd0;
      end else if (st_r == BK_MAC) begin
        s_r <= s_r + 5'd1;
      end
      if (emit && !last) begin
        d_r <= d_r + 3'd1;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stores: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[{head.dof[DW-1:0], head.ci}] <= head.value;
    end
    if (coef_rd) begin
      coef_q_r <= coef_mem[{d_r[DW-1:0], step_cur.k}];
    end
  end

  always_ff @(posedge clk) begin
    if (goal_wr) begin
      goal_mem[head.dof[DW-1:0]] <= head.value;
    end
    if (goal_rd) begin
      goal_q_r <= goal_mem[d_r[DW-1:0]];
    end
  end

  // Power unit: two 32x32 partial products, then round and keep Q40.24.
  always_ff @(posedge clk) begin
    if (load_eval) begin
      cmd_r     <= head;
      pw_r[0]   <= PW_ONE;
      pw_last_r <= PW_ONE;
    end else if (st_r == BK_POW) begin
      if (!ph_r) begin
        pp_lo_r <= pw_last_r[31:0] * cmd_r.stime;
        pp_hi_r <= pw_last_r[63:32] * cmd_r.stime;
      end else begin
        pw_r[k_r] <= pw_sum[87:24];
        pw_last_r <= pw_sum[87:24];
      end
    end
  end

  // Multiply-accumulate pipeline: weight, partial products, combine, accumulate.
  always_ff @(posedge clk) begin
    if (coef_rd) begin
      tag1_r <= step_cur;
    end
    if (v1_r) begin
      cw_r   <= $signed(coef_q_r) * $signed({1'b0, tag1_r.w});
      tag2_r <= tag1_r;
    end
    if (v2_r) begin
      ll_r   <= cw_r[31:0] * pw_sel[31:0];
      lh_r   <= cw_r[31:0] * pw_sel[63:32];
      hl_r   <= $signed(cw_r[53:32]) * $signed({1'b0, pw_sel[31:0]});
      hh_r   <= $signed(cw_r[53:32]) * $signed({1'b0, pw_sel[63:32]});
      tag3_r <= tag2_r;
    end
    if (v3_r) begin
      prod_r <= {54'b0, ll_r} + {22'b0, lh_r, 32'b0}
              + {{31{hl_r[54]}}, hl_r, 32'b0} + {hh_r[53:0], 64'b0};
      tag4_r <= tag3_r;
    end
    if (mac_enter) begin
      acc_pos_r <= '0;
      acc_vel_r <= '0;
      acc_acc_r <= '0;
    end else if (v4_r) begin
      case (tag4_r.sel)
        SEL_POS: acc_pos_r <= acc_pos_r + prod_ext;
        SEL_VEL: acc_vel_r <= acc_vel_r + prod_ext;
        default: acc_acc_r <= acc_acc_r + prod_ext;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (emit_acc) begin
      position     <= qte_round_sat(acc_pos_r);
      velocity     <= qte_round_sat(acc_vel_r);
      acceleration <= qte_round_sat(acc_acc_r);
    end else if (emit_goal) begin
      position     <= goal_q_r;
      velocity     <= 48'd0;
      acceleration <= 48'd0;
    end
    if (emit) begin
      dof_out      <= d_r;
      before_start <= cmd_r.early;
      is_last      <= last;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/quintic_trajectory_evaluator_top.sv */
// Top level of the quintic trajectory evaluator: ports, configuration registers, checks.
// Loads: one transfer per cycle while the queue has room; each is written to its store as
// it leaves the queue. Evaluate in range: dequeue, powers of the sample time, then per joint
// 15 products through the 5-stage multiply-accumulate and the result register. Evaluate past
// end time: one goal read per joint. Output stalls hold the back end in either case.
// Sync active-low reset clears control, queue and config (dof_count 1); stores are not cleared.
`timescale 1ns / 1ps
`include "quintic_trajectory_evaluator_top_macros.svh"
module quintic_trajectory_evaluator_top #(
  parameter int NUM_DOF = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  // Input stream.
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // dof_index[2:0], coef_index[5:3], load_value[53:6],
                                   // sample_time[85:54], zero pad[87:86]
  input  logic [1:0]   in_tuser,   // opcode[1:0]
  // Result stream.
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata,  // dof_out[2:0], position[50:3], velocity[98:51],
                                   // acceleration[146:99], zero pad[151:147]
  output logic [0:0]   out_tuser,  // before_start[0]
  output logic         out_tlast,  // is_last
  // Configuration port.
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import qte_pkg::*;

  localparam logic [2:0] MAX_DOF = 3'(((NUM_DOF < 8) ? NUM_DOF : 8) - 1);

  logic [31:0] start_r, end_r;
  logic [3:0]  dofs_r;
  logic        cfg_wr;

  logic          push, pop, emit;
  qte_cmd_t      push_cmd, head;
  qte_q_status_t q_stat;

  logic [2:0]  dof_o;
  logic [47:0] pos_o, vel_o, acc_o;
  logic        before_o, last_o;

  // Configuration: writes complete in the access phase, reads are combinational.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 32'd0;
      end_r   <= 32'd0;
      dofs_r  <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_START: start_r <= pwdata;
        REG_END:   end_r   <= pwdata;
        REG_DOFS:  dofs_r  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_START: prdata = start_r;
      REG_END:   prdata = end_r;
      REG_DOFS:  prdata = {28'd0, dofs_r};
      default:   prdata = 32'd0;
    endcase
  end

  // Front end: decode each transfer, drop ignored items, tag past/before.
  qte_front #(.NUM_DOF(NUM_DOF)) u_front (
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .opcode      (in_tuser),
    .dof_index   (in_tdata[2:0]),
    .coef_index  (in_tdata[5:3]),
    .load_value  (in_tdata[53:6]),
    .sample_time (in_tdata[85:54]),
    .start_time  (start_r),
    .end_time    (end_r),
    .dof_count   (dofs_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Queue: lets the front take up to two transfers while the back end works.
  qte_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .stat     (q_stat)
  );

  // Back end: stores, evaluation and the result register.
  qte_back #(.NUM_DOF(NUM_DOF)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_stat       (q_stat),
    .pop          (pop),
    .emit         (emit),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .dof_out      (dof_o),
    .position     (pos_o),
    .velocity     (vel_o),
    .acceleration (acc_o),
    .before_start (before_o),
    .is_last      (last_o)
  );

  assign out_tdata = {5'd0, acc_o, vel_o, pos_o, dof_o};
  assign out_tuser = before_o;
  assign out_tlast = last_o;

  // A result load always shows up on the output next cycle.
  `QTE_ASSERT_NEXT(a_emit_shows, emit, out_tvalid, "result load did not raise out_tvalid")
  // Queue occupancy never passes its depth.
  `QTE_ASSERT_NOW(a_queue_depth, 1'b1, q_stat.cnt != 2'd3, "command queue overflow")
  // Results only for joints that exist.
  `QTE_ASSERT_NOW(a_dof_range, out_tvalid, out_tdata[2:0] <= MAX_DOF, "result joint out of range")

endmodule

/* dv/quintic_trajectory_evaluator_top_tb.sv */
// Self-checking testbench of the quintic trajectory evaluator top level.
`timescale 1ns / 1ps
module quintic_trajectory_evaluator_top_tb;
  import qte_pkg::*;

  localparam int  MAX_JOINTS  = 8;
  localparam int  DRAIN_WAIT  = 220;     // longer than one full eight-joint evaluation
  localparam int  CYCLE_LIMIT = 600000;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam logic signed [127:0] SUM_MAX = 128'sh7FFF_FFFF_FFFF;
  localparam logic signed [127:0] SUM_MIN = -128'sh8000_0000_0000;

  typedef struct {
    logic [2:0]  dof;
    logic [47:0] pos;
    logic [47:0] vel;
    logic [47:0] acc;
    logic        early;
    logic        last;
  } joint_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [87:0]  in_tdata = '0;   // dof_index, coef_index, load_value, sample_time, pad
  logic [1:0]   in_tuser = '0;   // opcode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;       // dof_out, position, velocity, acceleration, pad
  logic [0:0]   out_tuser;       // before_start
  logic         out_tlast;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [3:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;

  quintic_trajectory_evaluator_top dut (.*);

  // Trajectory mirror: coefficients, goals and configuration.
  logic [47:0] coef_mem [MAX_JOINTS][NUM_COEF];
  logic [47:0] goal_mem [MAX_JOINTS];
  logic [31:0] start_reg = '0;
  logic [31:0] end_reg = '0;
  logic [3:0]  joints_reg = 4'd1;

  joint_result_t pending_joints[$];
  int errors = 0;
  int cycles = 0;
  bit no_idle = 1'b0;

  always #5 clk = ~clk;

  // Hard stop in case a transfer never completes.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** quintic_trajectory_evaluator_top: FAILED **");
      $finish;
    end
  end

  // Result side backpressure: stall about a quarter of the time unless quiet.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 24);
  end

  // Weighted polynomial sum at Q.48, rounded half up to Q24.24 and clamped.
  function automatic logic [47:0] poly_sum(input int d, input int order, input int wsel,
                                           input logic [63:0] pw [NUM_COEF]);
    int          wt_vel [NUM_COEF] = '{0, 1, 2, 3, 4, 5};
    int          wt_acc [NUM_COEF] = '{0, 0, 2, 6, 12, 20};
    logic signed [127:0] sum;
    logic signed [127:0] term;
    logic signed [63:0]  cw;
    logic [63:0]         mag;
    int                  w;
    sum = '0;
    for (int k = order; k < NUM_COEF; k++) begin
      w = (wsel == 0) ? 1 : (wsel == 1) ? wt_vel[k] : wt_acc[k];
      cw = 64'($signed(coef_mem[d][k])) * 64'(w);
      mag = cw[63] ? -cw : cw;
      term = {64'b0, mag} * {64'b0, pw[k - order]};
      sum = cw[63] ? sum - term : sum + term;
    end
    sum = (sum + 128'sh80_0000) >>> 24;
    if (sum > SUM_MAX) return SUM_MAX[47:0];
    if (sum < SUM_MIN) return SUM_MIN[47:0];
    return sum[47:0];
  endfunction

  // Update the mirror for one accepted item and queue the joint results it causes.
  function automatic void track_item(input logic [1:0] op, input logic [2:0] dof,
                                     input logic [2:0] ci, input logic [47:0] val,
                                     input logic [31:0] t);
    logic [63:0]   pw [NUM_COEF];
    logic [95:0]   prod;
    int            n;
    joint_result_t r;
    case (op)
      OP_LOAD_COEF: if (ci < NUM_COEF) coef_mem[dof][ci] = val;
      OP_LOAD_GOAL: goal_mem[dof] = val;
      OP_EVAL: begin
        n = (joints_reg == 0) ? 1 : (joints_reg > MAX_JOINTS) ? MAX_JOINTS : joints_reg;
        pw[0] = PW_ONE;
        for (int k = 1; k < NUM_COEF; k++) begin
          prod = 96'(pw[k-1]) * 96'(t) + 96'h80_0000;
          pw[k] = prod[87:24];
        end
        for (int d = 0; d < n; d++) begin
          r.dof = d[2:0];
          r.early = (t < start_reg);
          r.last = (d == n - 1);
          if (t > end_reg) begin
            r.pos = goal_mem[d];
            r.vel = '0;
            r.acc = '0;
          end else begin
            r.pos = poly_sum(d, 0, 0, pw);
            r.vel = poly_sum(d, 1, 1, pw);
            r.acc = poly_sum(d, 2, 2, pw);
          end
          pending_joints.push_back(r);
        end
      end
      default: ;
    endcase
  endfunction

  // Compare each result transfer with the oldest pending joint result.
  always @(posedge clk) begin
    joint_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_joints.size() == 0) begin
        $error("unexpected result transfer, dof_out %0d", out_tdata[2:0]);
        errors++;
      end else begin
        e = pending_joints.pop_front();
        if (out_tdata[2:0] !== e.dof) begin
          $error("dof_out exp %0d got %0d", e.dof, out_tdata[2:0]); errors++;
        end
        if (out_tdata[50:3] !== e.pos) begin
          $error("position exp %h got %h", e.pos, out_tdata[50:3]); errors++;
        end
        if (out_tdata[98:51] !== e.vel) begin
          $error("velocity exp %h got %h", e.vel, out_tdata[98:51]); errors++;
        end
        if (out_tdata[146:99] !== e.acc) begin
          $error("acceleration exp %h got %h", e.acc, out_tdata[146:99]); errors++;
        end
        if (out_tuser[0] !== e.early) begin
          $error("before_start exp %0d got %0d", e.early, out_tuser[0]); errors++;
        end
        if (out_tlast !== e.last) begin
          $error("is_last exp %0d got %0d", e.last, out_tlast); errors++;
        end
      end
    end
  end

  // Drive one item, hold it until the transfer, then track it.
  task automatic send_item(input logic [1:0] op, input logic [2:0] dof, input logic [2:0] ci,
                           input logic [47:0] val, input logic [31:0] t);
    if (!no_idle && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, t, val, ci, dof};
    do @(posedge clk); while (!in_tready);
    track_item(op, dof, ci, val, t);
  endtask

  // Drop valid and wait until every pending result has come back, plus the pipeline tail.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_joints.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_START: start_reg = value;
      REG_END:   end_reg = value;
      default:   joints_reg = value[3:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] st, input logic [31:0] et, input logic [3:0] n);
    drain();
    write_reg(REG_START, st);
    write_reg(REG_END, et);
    write_reg(REG_DOFS, {28'b0, n});
  endtask

  // Fill every store entry, including the most positive and negative values.
  task automatic test_fill_stores();
    for (int d = 0; d < MAX_JOINTS; d++) begin
      for (int k = 0; k < NUM_COEF; k++)
        send_item(OP_LOAD_COEF, d[2:0], k[2:0], (d == 0) ? 48'h7FFF_FFFF_FFFF :
                  (d == 1) ? 48'h8000_0000_0000 :
                  48'({$urandom_range(255), $urandom()} >>> 8),
                  $urandom());
      send_item(OP_LOAD_GOAL, d[2:0], 3'($urandom_range(7)),
                48'({$urandom_range(65535), $urandom()}), $urandom());
    end
  endtask

  // Reserved opcode and out-of-range coefficient slots must change nothing.
  task automatic test_ignored_items();
    send_item(OP_LOAD_COEF, 3'd2, 3'd6, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_LOAD_COEF, 3'd7, 3'd7, 48'h1234_5678_9ABC, 32'h0);
    send_item(OP_RESERVED, 3'd7, 3'd7, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // Time extremes at the current configuration: zero, boundaries and full scale.
  task automatic test_time_edges();
    send_item(OP_EVAL, 3'd0, 3'd0, '0, 32'h0);
    send_item(OP_EVAL, 3'd7, 3'd7, 48'hFFFF_FFFF_FFFF, end_reg);
    send_item(OP_EVAL, 3'd0, 3'd0, '0, end_reg + 32'd1);
    send_item(OP_EVAL, 3'd0, 3'd0, '0, start_reg - 32'd1);
    send_item(OP_EVAL, 3'd0, 3'd0, '0, 32'hFFFF_FFFF);
  endtask

  // Random mix: mostly evaluations and loads, a little noise.
  task automatic test_random_mix(input int count);
    logic [31:0] t;
    logic [47:0] v;
    logic [2:0]  rd;
    logic [2:0]  rc;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      case ($urandom_range(3))
        0: t = $urandom();
        1: t = $urandom_range(32'h0200_0000);
        2: t = start_reg + $urandom_range(16) - 8;
        default: t = end_reg + $urandom_range(16) - 8;
      endcase
      v = $urandom_range(1) ? 48'({$urandom_range(65535), $urandom()})
                            : 48'($signed($urandom()) >>> $urandom_range(20));
      rd = 3'($urandom_range(7));
      rc = 3'($urandom_range(7));
      if (pick < 45)      send_item(OP_EVAL, rd, rc, v, t);
      else if (pick < 75) send_item(OP_LOAD_COEF, rd, rc, v, t);
      else if (pick < 92) send_item(OP_LOAD_GOAL, rd, rc, v, t);
      else                send_item(OP_RESERVED, rd, rc, v, t);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_stores();
    test_ignored_items();
    test_time_edges();
    set_config(32'h0, 32'hFFFF_FFFF, 4'd8);
    test_time_edges();
    test_random_mix(40);
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd1);
    test_random_mix(20);
    set_config(32'h0, 32'h0, 4'd15);
    test_time_edges();
    test_random_mix(20);
    no_idle = 1'b1;
    set_config(32'h0100_0000, 32'h0300_0000, 4'd4);
    test_random_mix(40);
    no_idle = 1'b0;
    set_config($urandom(), $urandom(), 4'd0);
    test_random_mix(20);
    set_config(32'h0080_0000, 32'h0400_0000, 4'($urandom_range(2, 8)));
    test_random_mix(56);
    drain();
    if (errors == 0) begin
      $display("** quintic_trajectory_evaluator_top: PASSED **");
    end else begin
      $display("** quintic_trajectory_evaluator_top: FAILED **");
    end
    $finish;
  end
endmodule
